// ----- sv/rtt_pkg.sv -----
package rtt_pkg;

    localparam int WLEN_BITS   = 6;
    localparam int LEVEL_BITS  = 7;
    localparam int LIMIT_BITS  = 8;
    localparam int HOLD_BITS   = 9;
    localparam int CASH_BITS   = 48;
    localparam int ADDR_BITS   = 4;
    localparam int DATA_BITS   = 32;
    localparam int WLEN_MAX    = (1 << WLEN_BITS) - 1;
    localparam int WIN_LEN_MIN = 2;
    localparam int PCT_SCALE   = 100;

    typedef logic [1:0] reg_idx_t;

    localparam reg_idx_t REG_WINDOW_LEN  = 2'd0;
    localparam reg_idx_t REG_OVERSOLD    = 2'd1;
    localparam reg_idx_t REG_OVERBOUGHT  = 2'd2;
    localparam reg_idx_t REG_POS_LIMIT   = 2'd3;

    typedef enum logic [1:0] {
        ACT_HOLD = 2'd0,
        ACT_BUY  = 2'd1,
        ACT_SELL = 2'd2
    } action_t;

    typedef struct packed {
        logic [WLEN_BITS-1:0]  window_len;
        logic [LEVEL_BITS-1:0] oversold_level;
        logic [LEVEL_BITS-1:0] overbought_level;
        logic [LIMIT_BITS-1:0] position_limit;
    } cfg_t;

    localparam cfg_t CFG_RESET = '{
        window_len:       6'd14,
        oversold_level:   7'd30,
        overbought_level: 7'd70,
        position_limit:   8'd3
    };

endpackage

// ----- sv/rtt_price_if.sv -----
interface rtt_price_if #(
    parameter int PRICE_BITS = 24
);
    logic                  valid;
    logic                  ready;
    logic [PRICE_BITS-1:0] price;

    modport source (output valid, output price, input ready);
    modport sink   (input valid, input price, output ready);
endinterface

// ----- sv/rtt_result_if.sv -----
interface rtt_result_if #(
    parameter int SUM_BITS = 29
);
    import rtt_pkg::*;

    logic                        valid;
    logic                        ready;
    logic                        ready_res;
    action_t                     action;
    logic signed [HOLD_BITS-1:0] holding;
    logic signed [CASH_BITS-1:0] cash;
    logic [SUM_BITS-1:0]         gain_total;
    logic [SUM_BITS-1:0]         loss_total;

    modport source (output valid, output ready_res, output action, output holding,
                    output cash, output gain_total, output loss_total, input ready);
    modport sink   (input valid, input ready_res, input action, input holding,
                    input cash, input gain_total, input loss_total, output ready);
endinterface

// ----- sv/rtt_front.sv -----
module rtt_front #(
    parameter int PRICE_BITS = 24,
    parameter int WIN_CAP    = 32,
    parameter int SUM_BITS   = 29
) (
    input  logic                  clk,
    input  logic                  rst_n,
    input  rtt_pkg::cfg_t         cfg,
    input  logic                  clear,
    input  logic                  in_valid,
    output logic                  in_ready,
    input  logic [PRICE_BITS-1:0] in_price,
    output logic                  push_valid,
    input  logic                  push_ready,
    output logic [PRICE_BITS-1:0] push_price,
    output logic                  push_full,
    output logic [SUM_BITS-1:0]   push_gain,
    output logic [SUM_BITS-1:0]   push_loss
);
    import rtt_pkg::*;

    localparam int CH_BITS  = PRICE_BITS + 1;
    localparam int PTR_BITS = $clog2(WIN_CAP);
    localparam int CNT_BITS = $clog2(WIN_CAP + 2);

    logic signed [CH_BITS-1:0] ring_mem [WIN_CAP];

    logic [PRICE_BITS-1:0]     last_price_reg;
    logic [PTR_BITS-1:0]       ptr_reg;
    logic [PTR_BITS-1:0]       ptr_next;
    logic [CNT_BITS-1:0]       seen_reg;
    logic [CNT_BITS-1:0]       seen_next;
    logic [SUM_BITS-1:0]       gain_reg;
    logic [SUM_BITS-1:0]       gain_next;
    logic [SUM_BITS-1:0]       loss_reg;
    logic [SUM_BITS-1:0]       loss_next;

    logic                      f1_vld_reg;
    logic [PRICE_BITS-1:0]     f1_price_reg;
    logic signed [CH_BITS-1:0] f1_ch_reg;
    logic signed [CH_BITS-1:0] f1_old_reg;
    logic                      f1_drop_reg;
    logic                      f1_full_reg;

    logic [WLEN_BITS-1:0]      wlen_clamped;
    logic [CNT_BITS-1:0]       weff;
    logic                      accept;
    logic                      first;
    logic signed [CH_BITS-1:0] ch_new;
    logic                      advance;
    logic [PRICE_BITS-1:0]     ch_mag;
    logic [PRICE_BITS-1:0]     old_mag;
    logic [SUM_BITS-1:0]       gain_add;
    logic [SUM_BITS-1:0]       gain_sub;
    logic [SUM_BITS-1:0]       loss_add;
    logic [SUM_BITS-1:0]       loss_sub;

    always_comb
    begin
        if (cfg.window_len < WLEN_BITS'(WIN_LEN_MIN))
        begin
            wlen_clamped = WLEN_BITS'(WIN_LEN_MIN);
        end
        else if (cfg.window_len > WLEN_BITS'(WIN_CAP))
        begin
            wlen_clamped = WLEN_BITS'(WIN_CAP);
        end
        else
        begin
            wlen_clamped = cfg.window_len;
        end
    end

    assign weff     = CNT_BITS'(wlen_clamped);
    assign in_ready = !f1_vld_reg || push_ready;
    assign accept   = in_valid && in_ready;
    assign advance  = f1_vld_reg && push_ready;
    assign first    = (seen_reg == '0);
    assign ch_new   = $signed({1'b0, in_price}) - $signed({1'b0, last_price_reg});

    assign ptr_next = (CNT_BITS'(ptr_reg) == weff - CNT_BITS'(1)) ? '0
                                                                   : ptr_reg + PTR_BITS'(1);

    always_comb
    begin
        if (first)
        begin
            seen_next = CNT_BITS'(1);
        end
        else if (seen_reg <= weff)
        begin
            seen_next = seen_reg + CNT_BITS'(1);
        end
        else
        begin
            seen_next = seen_reg;
        end
    end

    // split the change leaving and the change entering the window into gain and loss
    assign ch_mag   = f1_ch_reg[CH_BITS-1] ? PRICE_BITS'(-f1_ch_reg) : PRICE_BITS'(f1_ch_reg);
    assign old_mag  = f1_old_reg[CH_BITS-1] ? PRICE_BITS'(-f1_old_reg) : PRICE_BITS'(f1_old_reg);
    assign gain_add = f1_ch_reg[CH_BITS-1] ? '0 : SUM_BITS'(ch_mag);
    assign loss_add = f1_ch_reg[CH_BITS-1] ? SUM_BITS'(ch_mag) : '0;
    assign gain_sub = (f1_drop_reg && !f1_old_reg[CH_BITS-1]) ? SUM_BITS'(old_mag) : '0;
    assign loss_sub = (f1_drop_reg && f1_old_reg[CH_BITS-1]) ? SUM_BITS'(old_mag) : '0;
    assign gain_next = gain_reg - gain_sub + gain_add;
    assign loss_next = loss_reg - loss_sub + loss_add;

    assign push_valid = f1_vld_reg;
    assign push_price = f1_price_reg;
    assign push_full  = f1_full_reg;
    assign push_gain  = gain_next;
    assign push_loss  = loss_next;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            last_price_reg <= '0;
            ptr_reg        <= '0;
            seen_reg       <= '0;
            gain_reg       <= '0;
            loss_reg       <= '0;
            f1_vld_reg     <= 1'b0;
        end
        else
        begin
            f1_vld_reg <= accept || (f1_vld_reg && !push_ready);
            if (clear)
            begin
                ptr_reg  <= '0;
                seen_reg <= '0;
                gain_reg <= '0;
                loss_reg <= '0;
            end
            else
            begin
                if (accept)
                begin
                    last_price_reg <= in_price;
                    seen_reg       <= seen_next;
                    if (!first)
                    begin
                        ptr_reg <= ptr_next;
                    end
                end
                if (advance)
                begin
                    gain_reg <= gain_next;
                    loss_reg <= loss_next;
                end
            end
        end
    end

    always_ff @(posedge clk)
    begin
        if (accept)
        begin
            f1_price_reg <= in_price;
            f1_ch_reg    <= first ? '0 : ch_new;
            f1_old_reg   <= ring_mem[ptr_reg];
            f1_drop_reg  <= !first && (seen_reg > weff);
            f1_full_reg  <= !first && (seen_reg >= weff);
        end
    end

    always_ff @(posedge clk)
    begin
        if (accept && !first)
        begin
            ring_mem[ptr_reg] <= ch_new;
        end
    end

endmodule

// ----- sv/rtt_queue.sv -----
module rtt_queue #(
    parameter int WIDTH = 8,
    parameter int DEPTH = 2
) (
    input  logic             clk,
    input  logic             rst_n,
    input  logic             push_valid,
    output logic             push_ready,
    input  logic [WIDTH-1:0] push_data,
    output logic             pop_valid,
    input  logic             pop_ready,
    output logic [WIDTH-1:0] pop_data
);
    localparam int PTR_BITS = $clog2(DEPTH);
    localparam int CNT_BITS = $clog2(DEPTH + 1);

    logic [WIDTH-1:0]    slot_reg [DEPTH];
    logic [PTR_BITS-1:0] wr_ptr_reg;
    logic [PTR_BITS-1:0] rd_ptr_reg;
    logic [CNT_BITS-1:0] count_reg;
    logic                push;
    logic                pop;

    assign push_ready = (count_reg != CNT_BITS'(DEPTH));
    assign pop_valid  = (count_reg != '0);
    assign pop_data   = slot_reg[rd_ptr_reg];
    assign push       = push_valid && push_ready;
    assign pop        = pop_valid && pop_ready;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            wr_ptr_reg <= '0;
            rd_ptr_reg <= '0;
            count_reg  <= '0;
        end
        else
        begin
            if (push)
            begin
                wr_ptr_reg <= (wr_ptr_reg == PTR_BITS'(DEPTH - 1)) ? '0
                                                                   : wr_ptr_reg + PTR_BITS'(1);
            end
            if (pop)
            begin
                rd_ptr_reg <= (rd_ptr_reg == PTR_BITS'(DEPTH - 1)) ? '0
                                                                   : rd_ptr_reg + PTR_BITS'(1);
            end
            if (push && !pop)
            begin
                count_reg <= count_reg + CNT_BITS'(1);
            end
            else if (pop && !push)
            begin
                count_reg <= count_reg - CNT_BITS'(1);
            end
        end
    end

    always_ff @(posedge clk)
    begin
        if (push)
        begin
            slot_reg[wr_ptr_reg] <= push_data;
        end
    end

endmodule

// ----- sv/rtt_back.sv -----
module rtt_back #(
    parameter int PRICE_BITS = 24,
    parameter int SUM_BITS   = 29
) (
    input  logic                                 clk,
    input  logic                                 rst_n,
    input  rtt_pkg::cfg_t                        cfg,
    input  logic                                 pop_valid,
    output logic                                 pop_ready,
    input  logic [PRICE_BITS-1:0]                pop_price,
    input  logic                                 pop_full,
    input  logic [SUM_BITS-1:0]                  pop_gain,
    input  logic [SUM_BITS-1:0]                  pop_loss,
    output logic                                 out_valid,
    input  logic                                 out_ready,
    output logic                                 out_ready_res,
    output rtt_pkg::action_t                     out_action,
    output logic signed [rtt_pkg::HOLD_BITS-1:0] out_holding,
    output logic signed [rtt_pkg::CASH_BITS-1:0] out_cash,
    output logic [SUM_BITS-1:0]                  out_gain,
    output logic [SUM_BITS-1:0]                  out_loss
);
    import rtt_pkg::*;

    localparam int PROD_BITS = SUM_BITS + LEVEL_BITS;

    logic                        b1_vld_reg;
    logic [PRICE_BITS-1:0]       b1_price_reg;
    logic                        b1_full_reg;
    logic [SUM_BITS-1:0]         b1_gain_reg;
    logic [SUM_BITS-1:0]         b1_loss_reg;
    logic [SUM_BITS-1:0]         b1_total_reg;
    logic [PROD_BITS-1:0]        b1_pg_reg;

    logic                        b2_vld_reg;
    logic [PRICE_BITS-1:0]       b2_price_reg;
    logic                        b2_full_reg;
    logic [SUM_BITS-1:0]         b2_gain_reg;
    logic [SUM_BITS-1:0]         b2_loss_reg;
    logic                        b2_sell_reg;
    logic                        b2_buy_reg;

    logic                        out_vld_reg;
    logic                        out_full_reg;
    action_t                     out_action_reg;
    logic [SUM_BITS-1:0]         out_gain_reg;
    logic [SUM_BITS-1:0]         out_loss_reg;
    logic signed [HOLD_BITS-1:0] holding_reg;
    logic signed [HOLD_BITS-1:0] holding_next;
    logic signed [CASH_BITS-1:0] cash_reg;
    logic signed [CASH_BITS-1:0] cash_next;

    logic                        take_b1;
    logic                        move_b2;
    logic                        move_out;
    logic                        total_nz;
    logic [PROD_BITS-1:0]        prod_ob;
    logic [PROD_BITS-1:0]        prod_os;
    logic signed [HOLD_BITS:0]   net_w;
    logic signed [HOLD_BITS:0]   lim_w;
    action_t                     act;
    logic signed [CASH_BITS:0]   cash_ext;
    logic signed [CASH_BITS:0]   price_ext;
    logic signed [CASH_BITS:0]   cash_sum;
    logic signed [CASH_BITS-1:0] cash_sat;

    assign move_out  = b2_vld_reg && (!out_vld_reg || out_ready);
    assign move_b2   = b1_vld_reg && (!b2_vld_reg || move_out);
    assign pop_ready = !b1_vld_reg || move_b2;
    assign take_b1   = pop_valid && pop_ready;

    assign total_nz = (b1_total_reg != '0);
    assign prod_ob  = PROD_BITS'(cfg.overbought_level) * PROD_BITS'(b1_total_reg);
    assign prod_os  = PROD_BITS'(cfg.oversold_level) * PROD_BITS'(b1_total_reg);

    assign net_w = {holding_reg[HOLD_BITS-1], holding_reg};
    assign lim_w = $signed({2'b00, cfg.position_limit});

    always_comb
    begin
        act = ACT_HOLD;
        if (b2_full_reg)
        begin
            if (b2_sell_reg && (net_w > -lim_w))
            begin
                act = ACT_SELL;
            end
            else if (b2_buy_reg && (net_w < lim_w))
            begin
                act = ACT_BUY;
            end
        end
    end

    // sell takes the price in, buy pays it out; clamp to the signed cash range
    assign cash_ext  = {cash_reg[CASH_BITS-1], cash_reg};
    assign price_ext = $signed({1'b0, CASH_BITS'(b2_price_reg)});
    assign cash_sum  = (act == ACT_BUY) ? cash_ext - price_ext : cash_ext + price_ext;

    always_comb
    begin
        if (cash_sum[CASH_BITS] != cash_sum[CASH_BITS-1])
        begin
            cash_sat = cash_sum[CASH_BITS] ? {1'b1, {(CASH_BITS-1){1'b0}}}
                                           : {1'b0, {(CASH_BITS-1){1'b1}}};
        end
        else
        begin
            cash_sat = cash_sum[CASH_BITS-1:0];
        end
    end

    always_comb
    begin
        holding_next = holding_reg;
        cash_next    = cash_reg;
        if (act == ACT_SELL)
        begin
            holding_next = holding_reg - HOLD_BITS'(1);
            cash_next    = cash_sat;
        end
        else if (act == ACT_BUY)
        begin
            holding_next = holding_reg + HOLD_BITS'(1);
            cash_next    = cash_sat;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            b1_vld_reg  <= 1'b0;
            b2_vld_reg  <= 1'b0;
            out_vld_reg <= 1'b0;
            holding_reg <= '0;
            cash_reg    <= '0;
        end
        else
        begin
            b1_vld_reg  <= take_b1 || (b1_vld_reg && !move_b2);
            b2_vld_reg  <= move_b2 || (b2_vld_reg && !move_out);
            out_vld_reg <= move_out || (out_vld_reg && !out_ready);
            if (move_out)
            begin
                holding_reg <= holding_next;
                cash_reg    <= cash_next;
            end
        end
    end

    always_ff @(posedge clk)
    begin
        if (take_b1)
        begin
            b1_price_reg <= pop_price;
            b1_full_reg  <= pop_full;
            b1_gain_reg  <= pop_gain;
            b1_loss_reg  <= pop_loss;
            b1_total_reg <= SUM_BITS'(pop_gain + pop_loss);
            b1_pg_reg    <= PROD_BITS'(pop_gain) * PROD_BITS'(PCT_SCALE);
        end
        if (move_b2)
        begin
            b2_price_reg <= b1_price_reg;
            b2_full_reg  <= b1_full_reg;
            b2_gain_reg  <= b1_gain_reg;
            b2_loss_reg  <= b1_loss_reg;
            b2_sell_reg  <= total_nz && (b1_pg_reg > prod_ob);
            b2_buy_reg   <= total_nz && (b1_pg_reg < prod_os);
        end
        if (move_out)
        begin
            out_full_reg   <= b2_full_reg;
            out_action_reg <= act;
            out_gain_reg   <= b2_gain_reg;
            out_loss_reg   <= b2_loss_reg;
        end
    end

    assign out_valid     = out_vld_reg;
    assign out_ready_res = out_full_reg;
    assign out_action    = out_action_reg;
    assign out_holding   = holding_reg;
    assign out_cash      = cash_reg;
    assign out_gain      = out_gain_reg;
    assign out_loss      = out_loss_reg;

endmodule

// ----- sv/rsi_threshold_trader.sv -----
// Relative strength index trader over a moving window of price changes.
// prices (valid/ready): one closing price per transaction, in hundredths.
// results (valid/ready): exactly one result transaction per price, in order:
//   window-full flag, action (hold/buy/sell), holding, cash, gain and loss sums.
// APB port: window_len at 0x0, oversold_level at 0x4, overbought_level at 0x8,
//   position_limit at 0xC; pready is always high. Writing window_len empties
//   the window; holding and cash are kept. Write only while the block is idle.
// Path: a result passes the change stage, queue, product stage, compare stage
//   and decision register, in that order, before it is presented.
// Throughput: one price per cycle while results flow. The running sums take one
//   add and one subtract per item; the ring of changes has one read and one
//   write port. A two-entry queue separates the window front end from the
//   decision back end, so a stalled receiver holds the back end and fills the
//   queue before prices are refused; no transaction is lost or repeated.
// Reset: registers return to 14, 30, 70, 3; the window, sums, holding and cash
//   clear and both channels go idle. No clearing pass is needed.
module rsi_threshold_trader #(
    parameter int WINDOW_MAX = 32,
    parameter int PRICE_BITS = 24
) (
    input  logic                            clk,
    input  logic                            rst_n,
    rtt_price_if.sink                       prices,
    rtt_result_if.source                    results,
    input  logic                            psel,
    input  logic                            penable,
    input  logic                            pwrite,
    input  logic [rtt_pkg::ADDR_BITS-1:0]   paddr,
    input  logic [rtt_pkg::DATA_BITS-1:0]   pwdata,
    output logic [rtt_pkg::DATA_BITS-1:0]   prdata,
    output logic                            pready
);
    import rtt_pkg::*;

    localparam int WIN_CAP  = (WINDOW_MAX < WLEN_MAX) ? WINDOW_MAX : WLEN_MAX;
    localparam int SUM_BITS = PRICE_BITS + $clog2(WIN_CAP);
    localparam int Q_WIDTH  = PRICE_BITS + 1 + 2 * SUM_BITS;

    cfg_t                  cfg_reg;
    logic                  wr_en;
    reg_idx_t              wr_idx;
    logic                  clear;

    logic                  push_valid;
    logic                  push_ready;
    logic [PRICE_BITS-1:0] push_price;
    logic                  push_full;
    logic [SUM_BITS-1:0]   push_gain;
    logic [SUM_BITS-1:0]   push_loss;
    logic                  pop_valid;
    logic                  pop_ready;
    logic [Q_WIDTH-1:0]    pop_data;

    assign pready = 1'b1;
    assign wr_en  = psel && penable && pwrite && pready;
    assign wr_idx = reg_idx_t'(paddr[ADDR_BITS-1:2]);
    assign clear  = wr_en && (wr_idx == REG_WINDOW_LEN);

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            cfg_reg <= CFG_RESET;
        end
        else if (wr_en)
        begin
            case (wr_idx)
                REG_WINDOW_LEN: cfg_reg.window_len       <= pwdata[WLEN_BITS-1:0];
                REG_OVERSOLD:   cfg_reg.oversold_level   <= pwdata[LEVEL_BITS-1:0];
                REG_OVERBOUGHT: cfg_reg.overbought_level <= pwdata[LEVEL_BITS-1:0];
                REG_POS_LIMIT:  cfg_reg.position_limit   <= pwdata[LIMIT_BITS-1:0];
                default:        cfg_reg                  <= cfg_reg;
            endcase
        end
    end

    always_comb
    begin
        case (reg_idx_t'(paddr[ADDR_BITS-1:2]))
            REG_WINDOW_LEN: prdata = DATA_BITS'(cfg_reg.window_len);
            REG_OVERSOLD:   prdata = DATA_BITS'(cfg_reg.oversold_level);
            REG_OVERBOUGHT: prdata = DATA_BITS'(cfg_reg.overbought_level);
            REG_POS_LIMIT:  prdata = DATA_BITS'(cfg_reg.position_limit);
            default:        prdata = '0;
        endcase
    end

    rtt_front #(
        .PRICE_BITS (PRICE_BITS),
        .WIN_CAP    (WIN_CAP),
        .SUM_BITS   (SUM_BITS)
    ) u_front (
        .clk        (clk),
        .rst_n      (rst_n),
        .cfg        (cfg_reg),
        .clear      (clear),
        .in_valid   (prices.valid),
        .in_ready   (prices.ready),
        .in_price   (prices.price),
        .push_valid (push_valid),
        .push_ready (push_ready),
        .push_price (push_price),
        .push_full  (push_full),
        .push_gain  (push_gain),
        .push_loss  (push_loss)
    );

    rtt_queue #(
        .WIDTH      (Q_WIDTH),
        .DEPTH      (2)
    ) u_queue (
        .clk        (clk),
        .rst_n      (rst_n),
        .push_valid (push_valid),
        .push_ready (push_ready),
        .push_data  ({push_price, push_full, push_gain, push_loss}),
        .pop_valid  (pop_valid),
        .pop_ready  (pop_ready),
        .pop_data   (pop_data)
    );

    rtt_back #(
        .PRICE_BITS    (PRICE_BITS),
        .SUM_BITS      (SUM_BITS)
    ) u_back (
        .clk           (clk),
        .rst_n         (rst_n),
        .cfg           (cfg_reg),
        .pop_valid     (pop_valid),
        .pop_ready     (pop_ready),
        .pop_price     (pop_data[Q_WIDTH-1 -: PRICE_BITS]),
        .pop_full      (pop_data[2 * SUM_BITS]),
        .pop_gain      (pop_data[2 * SUM_BITS - 1 -: SUM_BITS]),
        .pop_loss      (pop_data[SUM_BITS-1:0]),
        .out_valid     (results.valid),
        .out_ready     (results.ready),
        .out_ready_res (results.ready_res),
        .out_action    (results.action),
        .out_holding   (results.holding),
        .out_cash      (results.cash),
        .out_gain      (results.gain_total),
        .out_loss      (results.loss_total)
    );

endmodule

// ----- sv/rtt_checker.sv -----
module rtt_checker #(
    parameter int SUM_BITS = 29
) (
    input logic                                 clk,
    input logic                                 rst_n,
    input logic                                 res_valid,
    input logic                                 res_ready,
    input logic                                 res_ready_res,
    input logic [1:0]                           res_action,
    input logic signed [rtt_pkg::HOLD_BITS-1:0] res_holding,
    input logic signed [rtt_pkg::CASH_BITS-1:0] res_cash,
    input logic [SUM_BITS-1:0]                  res_gain,
    input logic [SUM_BITS-1:0]                  res_loss
);
    import rtt_pkg::*;

    a_hold_until_full: assert property (@(posedge clk) disable iff (!rst_n)
        res_valid && !res_ready_res |-> res_action == ACT_HOLD)
        else $error("trade issued before the window was full");

    a_hold_no_movement: assert property (@(posedge clk) disable iff (!rst_n)
        res_valid && res_gain == '0 && res_loss == '0 |-> res_action == ACT_HOLD)
        else $error("trade issued with no price movement in the window");

    a_stall_holds: assert property (@(posedge clk) disable iff (!rst_n)
        res_valid && !res_ready |=> res_valid && $stable(res_action)
            && $stable(res_holding) && $stable(res_cash) && $stable(res_gain)
            && $stable(res_loss) && $stable(res_ready_res))
        else $error("stalled result transaction changed or vanished");

    a_idle_after_reset: assert property (@(posedge clk)
        !$past(rst_n) |-> !res_valid)
        else $error("result presented straight out of reset");

endmodule

bind rsi_threshold_trader rtt_checker #(
    .SUM_BITS      (SUM_BITS)
) u_rtt_checker (
    .clk           (clk),
    .rst_n         (rst_n),
    .res_valid     (results.valid),
    .res_ready     (results.ready),
    .res_ready_res (results.ready_res),
    .res_action    (results.action),
    .res_holding   (results.holding),
    .res_cash      (results.cash),
    .res_gain      (results.gain_total),
    .res_loss      (results.loss_total)
);

// ----- verif/rsi_threshold_trader_checker.sv -----
`timescale 1ns / 1ps
module rsi_threshold_trader_checker #(
    parameter int WINDOW_MAX = 32,
    parameter int PRICE_BITS = 24,
    parameter int SUM_BITS   = 29
) (
    input  logic                                 clk,
    input  logic                                 rst_n,
    input  logic                                 price_valid,
    input  logic                                 price_ready,
    input  logic [PRICE_BITS-1:0]                price,
    input  logic                                 res_valid,
    input  logic                                 res_ready,
    input  logic                                 ready_res,
    input  rtt_pkg::action_t                     action,
    input  logic signed [rtt_pkg::HOLD_BITS-1:0] holding,
    input  logic signed [rtt_pkg::CASH_BITS-1:0] cash,
    input  logic [SUM_BITS-1:0]                  gain_total,
    input  logic [SUM_BITS-1:0]                  loss_total,
    input  logic                                 psel,
    input  logic                                 penable,
    input  logic                                 pwrite,
    input  logic                                 pready,
    input  logic [rtt_pkg::ADDR_BITS-1:0]        paddr,
    input  logic [rtt_pkg::DATA_BITS-1:0]        pwdata,
    output int                                   fail_count,
    output int                                   outstanding
);
    import rtt_pkg::*;

    localparam longint CASH_TOP    = (longint'(1) <<< (CASH_BITS - 1)) - 1;
    localparam longint CASH_BOTTOM = -CASH_TOP - 1;

    typedef struct {
        logic                        ready_res;
        action_t                     action;
        logic signed [HOLD_BITS-1:0] holding;
        logic signed [CASH_BITS-1:0] cash;
        logic [SUM_BITS-1:0]         gain_total;
        logic [SUM_BITS-1:0]         loss_total;
    } trade_t;

    cfg_t   cfg;
    longint change_hist [WINDOW_MAX];
    int     ring_pos;
    int     prices_seen;
    int     units;
    longint prev_price;
    longint gain_sum;
    longint loss_acc;
    longint balance;
    trade_t trade_queue [$];

    function automatic void clear_window();
        foreach (change_hist[i])
            change_hist[i] = 0;
        ring_pos    = 0;
        prices_seen = 0;
        gain_sum    = 0;
        loss_acc    = 0;
    endfunction

    function automatic longint clamp_cash(input longint v);
        if (v > CASH_TOP)
            return CASH_TOP;
        if (v < CASH_BOTTOM)
            return CASH_BOTTOM;
        return v;
    endfunction

    function automatic void apply_write(input logic [ADDR_BITS-1:0] addr,
                                        input logic [DATA_BITS-1:0] data);
        reg_idx_t idx;
        idx = reg_idx_t'(addr >> 2);
        case (idx)
            REG_WINDOW_LEN:
            begin
                cfg.window_len = data[WLEN_BITS-1:0];
                clear_window();
            end
            REG_OVERSOLD:   cfg.oversold_level   = data[LEVEL_BITS-1:0];
            REG_OVERBOUGHT: cfg.overbought_level = data[LEVEL_BITS-1:0];
            REG_POS_LIMIT:  cfg.position_limit   = data[LIMIT_BITS-1:0];
            default: ;
        endcase
    endfunction

    function automatic trade_t predict_trade(input logic [PRICE_BITS-1:0] p);
        trade_t r;
        int     w;
        longint delta;
        longint aged;
        longint g;
        longint t;
        longint lim;
        w = int'(cfg.window_len);
        if (w < WIN_LEN_MIN)
            w = WIN_LEN_MIN;
        if (w > WINDOW_MAX)
            w = WINDOW_MAX;
        r.ready_res = 1'b0;
        r.action    = ACT_HOLD;
        if (prices_seen == 0)
        begin
            prev_price  = longint'(p);
            prices_seen = 1;
        end
        else
        begin
            delta = longint'(p) - prev_price;
            if (ring_pos >= w)
                ring_pos = 0;
            if (prices_seen > w)
            begin
                aged = change_hist[ring_pos];
                if (aged > 0)
                    gain_sum -= aged;
                else
                    loss_acc += aged;
            end
            if (delta > 0)
                gain_sum += delta;
            else
                loss_acc -= delta;
            change_hist[ring_pos] = delta;
            ring_pos++;
            if (ring_pos >= w)
                ring_pos = 0;
            if (prices_seen <= w)
                prices_seen++;
            prev_price = longint'(p);

            if (prices_seen > w)
            begin
                r.ready_res = 1'b1;
                g   = gain_sum;
                t   = gain_sum + loss_acc;
                lim = longint'(cfg.position_limit);
                if (t != 0)
                begin
                    if (PCT_SCALE * g > longint'(cfg.overbought_level) * t && units > -lim)
                    begin
                        r.action = ACT_SELL;
                        units--;
                        balance = clamp_cash(balance + longint'(p));
                    end
                    else if (PCT_SCALE * g < longint'(cfg.oversold_level) * t
                             && units < lim)
                    begin
                        r.action = ACT_BUY;
                        units++;
                        balance = clamp_cash(balance - longint'(p));
                    end
                end
            end
        end
        r.holding    = units[HOLD_BITS-1:0];
        r.cash       = balance[CASH_BITS-1:0];
        r.gain_total = gain_sum[SUM_BITS-1:0];
        r.loss_total = loss_acc[SUM_BITS-1:0];
        return r;
    endfunction

    task automatic check_field(input string name, input logic [63:0] want,
                               input logic [63:0] got);
        if (got !== want)
        begin
            fail_count++;
            $display("%0t: %s mismatch, expected %0h, got %0h", $time, name, want, got);
        end
    endtask

    initial
    begin
        fail_count  = 0;
        outstanding = 0;
    end

    always @(posedge clk or negedge rst_n)
    begin
        trade_t want;
        if (!rst_n)
        begin
            cfg = CFG_RESET;
            clear_window();
            prev_price = 0;
            units      = 0;
            balance    = 0;
            trade_queue.delete();
        end
        else
        begin
            if (psel && penable && pwrite && pready)
                apply_write(paddr, pwdata);
            if (price_valid && price_ready)
                trade_queue = {trade_queue, predict_trade(price)};
            if (res_valid && res_ready)
            begin
                if (trade_queue.size() == 0)
                begin
                    fail_count++;
                    $display("%0t: result transaction with no price pending, got action %0h",
                             $time, action);
                end
                else
                begin
                    want = trade_queue.pop_front();
                    check_field("ready_res", want.ready_res, ready_res);
                    check_field("action", want.action, action);
                    check_field("holding", want.holding, holding);
                    check_field("cash", want.cash, cash);
                    check_field("gain_total", want.gain_total, gain_total);
                    check_field("loss_total", want.loss_total, loss_total);
                end
            end
        end
        outstanding = trade_queue.size();
    end

endmodule

// ----- verif/rsi_threshold_trader_tb.sv -----
`timescale 1ns / 1ps
module rsi_threshold_trader_tb;
    import rtt_pkg::*;

    localparam int                    WINDOW_MAX      = 32;
    localparam int                    PRICE_BITS      = 24;
    localparam int                    SUM_BITS        = 29;
    localparam logic [PRICE_BITS-1:0] PRICE_TOP       = '1;
    localparam int                    HOLD_OFF_CYCLES = 120;
    localparam int                    PHASES          = 10;
    localparam int                    PHASE_ITEMS     = 95;
    localparam int                    TAIL_ITEMS      = 150;
    localparam int                    TIMEOUT_NS      = 1000000;

    logic                  clk     = 1'b0;
    logic                  rst_n   = 1'b0;
    logic                  psel    = 1'b0;
    logic                  penable = 1'b0;
    logic                  pwrite  = 1'b0;
    logic [ADDR_BITS-1:0]  paddr   = '0;
    logic [DATA_BITS-1:0]  pwdata  = '0;
    logic [DATA_BITS-1:0]  prdata;
    logic                  pready;
    int                    fail_count;
    int                    outstanding;
    bit                    src_jitter   = 1'b0;
    bit                    sink_jitter  = 1'b0;
    bit                    hold_off_req = 1'b0;
    logic [PRICE_BITS-1:0] last_sent    = '0;

    rtt_price_if  #(.PRICE_BITS(PRICE_BITS)) price_ch ();
    rtt_result_if #(.SUM_BITS(SUM_BITS))     result_ch ();

    rsi_threshold_trader #(
        .WINDOW_MAX(WINDOW_MAX),
        .PRICE_BITS(PRICE_BITS)
    ) dut (
        .clk     (clk),
        .rst_n   (rst_n),
        .prices  (price_ch),
        .results (result_ch),
        .psel    (psel),
        .penable (penable),
        .pwrite  (pwrite),
        .paddr   (paddr),
        .pwdata  (pwdata),
        .prdata  (prdata),
        .pready  (pready)
    );

    rsi_threshold_trader_checker #(
        .WINDOW_MAX(WINDOW_MAX),
        .PRICE_BITS(PRICE_BITS),
        .SUM_BITS  (SUM_BITS)
    ) trade_chk (
        .clk         (clk),
        .rst_n       (rst_n),
        .price_valid (price_ch.valid),
        .price_ready (price_ch.ready),
        .price       (price_ch.price),
        .res_valid   (result_ch.valid),
        .res_ready   (result_ch.ready),
        .ready_res   (result_ch.ready_res),
        .action      (result_ch.action),
        .holding     (result_ch.holding),
        .cash        (result_ch.cash),
        .gain_total  (result_ch.gain_total),
        .loss_total  (result_ch.loss_total),
        .psel        (psel),
        .penable     (penable),
        .pwrite      (pwrite),
        .pready      (pready),
        .paddr       (paddr),
        .pwdata      (pwdata),
        .fail_count  (fail_count),
        .outstanding (outstanding)
    );

    always #1 clk = ~clk;

    initial
    begin
        #(TIMEOUT_NS);
        $display("tb: failure");
        $finish;
    end

    initial
    begin : result_sink
        int gap;
        result_ch.ready = 1'b0;
        forever
        begin
            @(negedge clk);
            if (hold_off_req)
            begin
                hold_off_req = 1'b0;
                result_ch.ready <= 1'b0;
                repeat (HOLD_OFF_CYCLES) @(negedge clk);
                result_ch.ready <= 1'b1;
            end
            else if (sink_jitter && $urandom_range(0, 7) == 0)
            begin
                gap = $urandom_range(1, 19);
                result_ch.ready <= 1'b0;
                repeat (gap) @(negedge clk);
                result_ch.ready <= 1'b1;
            end
            else
            begin
                result_ch.ready <= 1'b1;
            end
        end
    end

    task automatic apb_write(input reg_idx_t idx, input int val, input int width);
        logic [DATA_BITS-1:0] word;
        word = DATA_BITS'(val);
        if ($urandom_range(0, 1))
            word = word | ($urandom << width);
        @(negedge clk);
        psel    <= 1'b1;
        penable <= 1'b0;
        pwrite  <= 1'b1;
        paddr   <= ADDR_BITS'({idx, 2'b00});
        pwdata  <= word;
        @(negedge clk);
        penable <= 1'b1;
        do
            @(posedge clk);
        while (!pready);
        @(negedge clk);
        psel    <= 1'b0;
        penable <= 1'b0;
        pwrite  <= 1'b0;
    endtask

    // hold the sender idle until every pending result has been taken
    task automatic drain();
        @(negedge clk);
        price_ch.valid <= 1'b0;
        while (outstanding != 0)
            @(negedge clk);
    endtask

    task automatic configure(input int wlen, input int oversold, input int overbought,
                             input int limit);
        drain();
        if (wlen >= 0)
            apb_write(REG_WINDOW_LEN, wlen, WLEN_BITS);
        apb_write(REG_OVERSOLD, oversold, LEVEL_BITS);
        apb_write(REG_OVERBOUGHT, overbought, LEVEL_BITS);
        apb_write(REG_POS_LIMIT, limit, LIMIT_BITS);
    endtask

    task automatic send_price(input logic [PRICE_BITS-1:0] p);
        int gap;
        if (src_jitter && $urandom_range(0, 7) == 0)
        begin
            gap = $urandom_range(1, 19);
            @(negedge clk);
            price_ch.valid <= 1'b0;
            repeat (gap - 1) @(negedge clk);
        end
        @(negedge clk);
        price_ch.valid <= 1'b1;
        price_ch.price <= p;
        do
            @(posedge clk);
        while (!price_ch.ready);
        last_sent = p;
    endtask

    function automatic logic [PRICE_BITS-1:0] next_price(input logic [PRICE_BITS-1:0] cur,
                                                         input int drift);
        longint v;
        longint step;
        bit     up;
        case ($urandom_range(0, 31))
            0:       return '0;
            1:       return PRICE_TOP;
            2:       return PRICE_BITS'($urandom);
            3, 4, 5: return cur;
            default:
            begin
                step = longint'($urandom_range(0, 1 << $urandom_range(0, 12)));
                if (drift > 0)
                    up = ($urandom_range(0, 3) != 0);
                else if (drift < 0)
                    up = ($urandom_range(0, 3) == 0);
                else
                    up = $urandom_range(0, 1);
                v = up ? longint'(cur) + step : longint'(cur) - step;
                if (v < 0)
                    v = 0;
                if (v > longint'(PRICE_TOP))
                    v = longint'(PRICE_TOP);
                return v[PRICE_BITS-1:0];
            end
        endcase
    endfunction

    initial
    begin : stimulus
        int drift;
        int wl;
        price_ch.valid = 1'b0;
        price_ch.price = '0;
        drift = 0;
        repeat (11) @(posedge clk);
        @(negedge clk);
        rst_n <= 1'b1;

        // two-change window, one unit either way
        configure(2, 30, 70, 1);
        send_price('0);
        send_price(PRICE_TOP);
        send_price(PRICE_TOP);
        send_price(PRICE_TOP);
        send_price('0);
        send_price('0);
        send_price('0);
        send_price('0);
        send_price(PRICE_BITS'(5));
        send_price(PRICE_BITS'(10));
        send_price(PRICE_BITS'(20));
        send_price(PRICE_BITS'(10));
        send_price(PRICE_BITS'(5));
        send_price(PRICE_BITS'(2));
        send_price(PRICE_BITS'(1));
        send_price(PRICE_BITS'(3));
        send_price(24'hAAAAAA);
        send_price(24'h555555);

        for (int ph = 0; ph < PHASES; ph++)
        begin
            case (ph)
                0: configure(14, 30, 70, 3);
                1: configure(32, 0, 100, 255);
                2: configure(-1, 45, 55, 5);
                3: configure(0, 50, 50, 2);
                4: configure(63, 127, 127, 0);
                5: configure(1, 127, 0, 255);
                6: configure(33, 40, 60, 10);
                default:
                begin
                    wl = $urandom_range(0, 63);
                    if ($urandom_range(0, 3) == 0)
                        wl = -1;
                    configure(wl, $urandom_range(0, 127), $urandom_range(0, 127),
                              $urandom_range(0, 1) ? $urandom_range(0, 8)
                                                   : $urandom_range(0, 255));
                end
            endcase
            src_jitter  = (ph % 3 != 1);
            sink_jitter = (ph % 4 != 2);
            if (ph == 2)
            begin
                @(posedge clk);
                hold_off_req = 1'b1;
            end
            for (int i = 0; i < PHASE_ITEMS; i++)
            begin
                if (i % 30 == 0)
                    drift = int'($urandom_range(0, 2)) - 1;
                if (ph == 4 && i == 50)
                    drain();
                send_price(next_price(last_sent, drift));
            end
        end

        src_jitter  = 1'b0;
        sink_jitter = 1'b0;
        for (int i = 0; i < TAIL_ITEMS; i++)
        begin
            if (i % 30 == 0)
                drift = int'($urandom_range(0, 2)) - 1;
            send_price(next_price(last_sent, drift));
        end

        drain();
        repeat (20) @(negedge clk);
        if (fail_count == 0 && outstanding == 0)
            $display("tb: success");
        else
            $display("tb: failure");
        $finish;
    end

endmodule
